FILE: design/keyboard_scan_responder_assert.svh
// Assertion macros for the keyboard scan responder checker.
// Each macro samples on the rising edge of i_clk and is off while reset is held.
`ifndef KEYBOARD_SCAN_RESPONDER_ASSERT_SVH
`define KEYBOARD_SCAN_RESPONDER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define KSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyboard_scan_responder: port check failed");

// The consequent holds in the cycle after the antecedent.
`define KSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyboard_scan_responder: port check failed");

// Like KSR_ASSERT_NEXT, but the consequent is checked later.
`define KSR_ASSERT_LATER(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> ##1 (cons)) \
        else $error("keyboard_scan_responder: port check failed");

`endif

FILE: design/kbsr_pkg.sv
package kbsr_pkg;

    localparam int KEY_CODES  = 128;
    localparam int BYTE_TICKS = 160;

    localparam int KEY_W   = $clog2(KEY_CODES);
    localparam int POS_W   = 8;
    localparam int DLY_W   = 9;
    localparam int BUSY_W  = 8;
    localparam int BEEP_W  = 6;
    localparam int CNT_W   = 2;

    localparam int BEEP_MOD      = 48;
    localparam int NO_KEY_DELAY  = 127;
    localparam logic [7:0] END_MARKER = 8'h7f;
    localparam int SCAN_BIT = 6;
    localparam int BEEP_BIT = 7;

    typedef enum logic [1:0] {
        OP_FALL   = 2'd0,
        OP_RISE   = 2'd1,
        OP_STATUS = 2'd2,
        OP_KEY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_SENDING    = 2'd1,
        MODE_RESPONDING = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_ONE  = 2'd1,
        PHASE_TWO  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic       latch_strobe;
        logic [7:0] latch_value;
        logic       tx_empty;
        logic       beep_pulse;
    } t_out_beat;

    // Handshake view of the output register, handed from the core to the top.
    typedef struct packed {
        logic valid;
        logic blocked;
    } t_out_flow;

endpackage

FILE: design/keyboard_scan_responder.sv
// Keyboard scan responder: an emulated terminal keyboard driven one beat at a
// time. Each input beat carries an opcode (falling tick, rising tick, status
// write or key press) and a data byte; each accepted input beat yields exactly
// one output beat with the latch strobe, the latched scan code, the transmit
// empty flag and the beep pulse as they stand after that beat.
// Both channels use valid and stall: a beat moves on a rising edge where valid
// is high and stall is low. The block registers the input beat, does all the
// work for it in combinational logic, and registers the result. A new beat
// can be taken every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and one more
// input beat is taken into the input register; only then does o_in_stall rise,
// and it falls in the same cycle the stall is released.
// Reset is synchronous and active low. It empties both registers, clears the
// pressed and scan key maps and all counters, and puts the scan sequencer idle.
// The next key of a scan is found by a registered lowest-bit search over the
// 128-entry scan map, which keeps that search off the per-beat path.
module keyboard_scan_responder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kbsr_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kbsr_pkg::t_out_beat o_out_beat
);

    logic                           r_in_valid;
    kbsr_pkg::t_in_beat             r_in;
    logic                           adv;
    kbsr_pkg::t_out_flow            flow;
    logic [kbsr_pkg::KEY_CODES-1:0] scan_map;
    logic [kbsr_pkg::POS_W-1:0]     scan_pos;
    logic [kbsr_pkg::POS_W-1:0]     next_pos;

    // The held input beat moves on whenever the output register can take it.
    assign adv        = r_in_valid && !flow.blocked;
    assign o_in_stall = r_in_valid && flow.blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload only moves when the stage is free; it needs no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_beat;
        end
    end

    kbsr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_beat      (r_in),
        .i_next_pos  (next_pos),
        .i_out_stall (i_out_stall),
        .o_flow      (flow),
        .o_out_beat  (o_out_beat),
        .o_scan_map  (scan_map),
        .o_scan_pos  (scan_pos)
    );

    kbsr_next_key u_next_key (
        .i_clk  (i_clk),
        .i_map  (scan_map),
        .i_pos  (scan_pos),
        .o_next (next_pos)
    );

    assign o_out_valid = flow.valid;

endmodule

FILE: design/kbsr_next_key.sv
// Finds the lowest set bit of the scan map above the current scan position.
// The result is registered; it is read only after at least one tick has passed
// since the map or the position last changed, so it is always current by then.
module kbsr_next_key (
    input  logic                               i_clk,
    input  logic [kbsr_pkg::KEY_CODES-1:0]     i_map,
    input  logic [kbsr_pkg::POS_W-1:0]         i_pos,
    output logic [kbsr_pkg::POS_W-1:0]         o_next
);

    logic [kbsr_pkg::KEY_CODES-1:0] above;
    logic [kbsr_pkg::KEY_CODES-1:0] lowest;
    logic [kbsr_pkg::KEY_W-1:0]     idx;
    logic [kbsr_pkg::POS_W-1:0]     r_next;
    logic [kbsr_pkg::POS_W-1:0]     n_next;

    always_comb begin
        for (int k = 0; k < kbsr_pkg::KEY_CODES; k++) begin
            above[k] = i_map[k] && (kbsr_pkg::POS_W'(k) > i_pos);
        end
        // Isolate the lowest set bit, then encode its one-hot position.
        lowest = above & (~above + kbsr_pkg::KEY_CODES'(1));
    end

    always_comb begin
        logic [kbsr_pkg::KEY_W-1:0] kv;
        idx = '0;
        for (int k = 0; k < kbsr_pkg::KEY_CODES; k++) begin
            kv  = kbsr_pkg::KEY_W'(k);
            idx = idx | ({kbsr_pkg::KEY_W{lowest[k]}} & kv);
        end
        if (above == '0) begin
            n_next = kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES);
        end else begin
            n_next = kbsr_pkg::POS_W'(idx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_next <= n_next;
    end

    assign o_next = r_next;

endmodule

FILE: design/kbsr_core.sv
// Keyboard state and the result register. One beat is processed per cycle
// when i_adv is high.
module kbsr_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  kbsr_pkg::t_in_beat             i_beat,
    input  logic [kbsr_pkg::POS_W-1:0]     i_next_pos,
    input  logic                           i_out_stall,
    output kbsr_pkg::t_out_flow            o_flow,
    output kbsr_pkg::t_out_beat            o_out_beat,
    output logic [kbsr_pkg::KEY_CODES-1:0] o_scan_map,
    output logic [kbsr_pkg::POS_W-1:0]     o_scan_pos
);

    kbsr_pkg::t_mode                  r_mode, n_mode;
    kbsr_pkg::t_phase                 r_phase, n_phase;
    logic [kbsr_pkg::KEY_CODES-1:0]   r_pressed, n_pressed;
    logic [kbsr_pkg::KEY_CODES-1:0]   r_scan, n_scan;
    logic [kbsr_pkg::CNT_W-1:0]       r_pcnt, n_pcnt;
    logic [kbsr_pkg::POS_W-1:0]       r_pfirst, n_pfirst;
    logic [kbsr_pkg::POS_W-1:0]       r_sfirst, n_sfirst;
    logic [kbsr_pkg::CNT_W-1:0]       r_last, n_last;
    logic [kbsr_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [kbsr_pkg::DLY_W-1:0]       r_delay, n_delay;
    logic [kbsr_pkg::BUSY_W-1:0]      r_busy, n_busy;
    logic [kbsr_pkg::BEEP_W-1:0]      r_beep, n_beep;
    logic [7:0]                       r_latch, n_latch;
    logic                             r_out_valid, n_out_valid;
    kbsr_pkg::t_out_beat              r_out, n_out;

    kbsr_pkg::t_op                    op;
    logic [kbsr_pkg::KEY_W-1:0]       key_idx;
    logic                             key_ok;
    logic                             rollover;
    logic                             strobe;
    logic                             pulse;

    assign op      = kbsr_pkg::t_op'(i_beat.opcode);
    assign key_idx = i_beat.data_byte[kbsr_pkg::KEY_W-1:0];
    assign key_ok  = {1'b0, i_beat.data_byte} < 9'(kbsr_pkg::KEY_CODES);

    // Rollover: one key down now, one key in the last set, second send,
    // and that key was not part of the set being sent.
    assign rollover = (r_pcnt == kbsr_pkg::CNT_W'(1)) && (r_last == kbsr_pkg::CNT_W'(1))
                   && (r_phase == kbsr_pkg::PHASE_TWO)
                   && !r_scan[r_pfirst[kbsr_pkg::KEY_W-1:0]];

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_pressed = r_pressed;
        n_scan    = r_scan;
        n_pcnt    = r_pcnt;
        n_pfirst  = r_pfirst;
        n_sfirst  = r_sfirst;
        n_last    = r_last;
        n_pos     = r_pos;
        n_delay   = r_delay;
        n_busy    = r_busy;
        n_beep    = r_beep;
        n_latch   = r_latch;
        strobe    = 1'b0;
        pulse     = 1'b0;

        if (i_adv) begin
            case (op)
                kbsr_pkg::OP_RISE: begin
                    if (r_busy != '0) begin
                        n_busy = r_busy - kbsr_pkg::BUSY_W'(1);
                    end
                    case (r_mode)
                        kbsr_pkg::MODE_SENDING: begin
                            if (r_delay == '0) begin
                                if (rollover || (r_last == '0 && r_pcnt != '0)) begin
                                    n_scan    = r_pressed;
                                    n_sfirst  = r_pfirst;
                                    n_last    = r_pcnt;
                                    n_pressed = '0;
                                    n_pcnt    = '0;
                                    n_pfirst  = kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES);
                                    n_phase   = kbsr_pkg::PHASE_ONE;
                                end else if (r_last != '0 &&
                                             r_phase == kbsr_pkg::PHASE_ONE) begin
                                    n_phase = kbsr_pkg::PHASE_TWO;
                                end else begin
                                    n_scan   = '0;
                                    n_sfirst = kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES);
                                    n_last   = '0;
                                    n_phase  = kbsr_pkg::PHASE_IDLE;
                                end
                                n_pos  = n_sfirst;
                                n_mode = kbsr_pkg::MODE_RESPONDING;
                                if (n_sfirst < kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES)) begin
                                    n_delay = kbsr_pkg::DLY_W'(kbsr_pkg::BYTE_TICKS)
                                            + kbsr_pkg::DLY_W'(n_sfirst);
                                end else begin
                                    n_delay = kbsr_pkg::DLY_W'(kbsr_pkg::BYTE_TICKS)
                                            + kbsr_pkg::DLY_W'(kbsr_pkg::NO_KEY_DELAY);
                                end
                            end else begin
                                n_delay = r_delay - kbsr_pkg::DLY_W'(1);
                            end
                        end
                        kbsr_pkg::MODE_RESPONDING: begin
                            if (r_delay == '0) begin
                                strobe = 1'b1;
                                if (r_pos < kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES)) begin
                                    n_delay = kbsr_pkg::DLY_W'(kbsr_pkg::BYTE_TICKS);
                                    n_latch = 8'(r_pos);
                                    n_pos   = i_next_pos;
                                end else begin
                                    n_latch = kbsr_pkg::END_MARKER;
                                    n_mode  = kbsr_pkg::MODE_IDLE;
                                end
                            end else begin
                                n_delay = r_delay - kbsr_pkg::DLY_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                kbsr_pkg::OP_STATUS: begin
                    if (i_beat.data_byte[kbsr_pkg::SCAN_BIT] &&
                        r_mode == kbsr_pkg::MODE_IDLE) begin
                        n_mode  = kbsr_pkg::MODE_SENDING;
                        n_delay = kbsr_pkg::DLY_W'(2 * kbsr_pkg::BYTE_TICKS);
                    end
                    if (i_beat.data_byte[kbsr_pkg::BEEP_BIT]) begin
                        pulse = (r_beep == '0);
                        if (r_busy == '0) begin
                            if (r_beep == kbsr_pkg::BEEP_W'(kbsr_pkg::BEEP_MOD - 1)) begin
                                n_beep = '0;
                            end else begin
                                n_beep = r_beep + kbsr_pkg::BEEP_W'(1);
                            end
                        end
                    end else begin
                        n_beep = '0;
                    end
                    if (r_busy == '0) begin
                        n_busy = kbsr_pkg::BUSY_W'(kbsr_pkg::BYTE_TICKS);
                    end
                end
                kbsr_pkg::OP_KEY: begin
                    if (key_ok && !r_pressed[key_idx]) begin
                        n_pressed[key_idx] = 1'b1;
                        if (r_pcnt != '1) begin
                            n_pcnt = r_pcnt + kbsr_pkg::CNT_W'(1);
                        end
                        if (kbsr_pkg::POS_W'(key_idx) < r_pfirst) begin
                            n_pfirst = kbsr_pkg::POS_W'(key_idx);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        n_out.latch_strobe = strobe;
        n_out.latch_value  = n_latch;
        n_out.tx_empty     = (n_busy == '0);
        n_out.beep_pulse   = pulse;

        if (i_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kbsr_pkg::MODE_IDLE;
            r_phase     <= kbsr_pkg::PHASE_IDLE;
            r_pressed   <= '0;
            r_scan      <= '0;
            r_pcnt      <= '0;
            r_pfirst    <= kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES);
            r_sfirst    <= kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES);
            r_last      <= '0;
            r_pos       <= kbsr_pkg::POS_W'(kbsr_pkg::KEY_CODES);
            r_delay     <= '0;
            r_busy      <= '0;
            r_beep      <= '0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_pressed   <= n_pressed;
            r_scan      <= n_scan;
            r_pcnt      <= n_pcnt;
            r_pfirst    <= n_pfirst;
            r_sfirst    <= n_sfirst;
            r_last      <= n_last;
            r_pos       <= n_pos;
            r_delay     <= n_delay;
            r_busy      <= n_busy;
            r_beep      <= n_beep;
            r_latch     <= n_latch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_flow.valid   = r_out_valid;
    assign o_flow.blocked = r_out_valid && i_out_stall;
    assign o_out_beat     = r_out;
    assign o_scan_map     = r_scan;
    assign o_scan_pos     = r_pos;

endmodule

FILE: design/kbsr_checker.sv
`include "keyboard_scan_responder_assert.svh"

module kbsr_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  kbsr_pkg::t_in_beat  i_in_beat,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  kbsr_pkg::t_out_beat o_out_beat
);

    // The input side only backs up behind a stalled output beat.
    `KSR_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // An accepted beat drives o_out_valid high once it has passed both registers.
    `KSR_ASSERT_LATER(a_latency, i_in_valid && !o_in_stall, o_out_valid)

    // A stalled output beat stays put.
    `KSR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_beat))

    // A latch comes from a tick and a beep from a status write, never both.
    `KSR_ASSERT_NOW(a_one_cause, o_out_valid, !(o_out_beat.latch_strobe && o_out_beat.beep_pulse))

endmodule

bind keyboard_scan_responder kbsr_checker u_kbsr_checker (.*);
